// ===== rtl/core/ges_pkg.sv =====
// Shared types, constants and helper functions of the Gaussian elimination solver.
package ges_pkg;

  localparam int MAX_ROWS     = 4;
  localparam int MAX_UNKNOWNS = 4;
  localparam int MAX_RHS      = 2;
  localparam int COLS_MAX     = MAX_UNKNOWNS + MAX_RHS;
  localparam int DEPTH        = MAX_ROWS * COLS_MAX;
  localparam int AW           = $clog2(DEPTH);
  localparam int XS_DEPTH     = (MAX_UNKNOWNS + MAX_RHS) * MAX_UNKNOWNS;
  localparam int XAW          = $clog2(XS_DEPTH);
  localparam int ACC_W        = 36;

  localparam logic [2:0] CFG_ROWS      = 3'd0;
  localparam logic [2:0] CFG_UNKNOWNS  = 3'd1;
  localparam logic [2:0] CFG_RHS       = 3'd2;
  localparam logic [2:0] CFG_THRESHOLD = 3'd3;

  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_SOLUTION = 2'd1;
  localparam logic [1:0] KIND_BASIS    = 2'd2;

  localparam logic [1:0] STAT_NONE     = 2'd0;
  localparam logic [1:0] STAT_UNIQUE   = 2'd1;
  localparam logic [1:0] STAT_INFINITE = 2'd2;

  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] matrix_value;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [1:0]         solve_status;
    logic [1:0]         vector_number;
    logic [1:0]         free_unknown;
    logic [1:0]         unknown_index;
    logic signed [31:0] result_value;
    logic               saturated;
    logic               last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    W_IN, W_RD, W_A, W_ZERO, W_DIFF
  } wsel_t;

  typedef enum logic [1:0] {
    X_ZERO, X_ONE, X_QUOT
  } xsel_t;

  typedef struct packed {
    logic          mem_re;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    wsel_t         wsel;
    logic          piv_ld;
    logic          a_ld;
    logic          f_ld;
    logic          mul_en;
    logic          mul_x;
    logic          q_en;
    logic          acc_clr;
    logic          acc_add;
    logic          num_ld;
    logic          num_rd;
    logic          div_start;
    logic          div_acc;
    logic          x_we;
    xsel_t         xsel;
    logic [XAW-1:0] x_addr;
    logic          sat_clr;
    logic          emit;
    out_item_t     item;
    logic [15:0]   thr;
  } dp_cmd_t;

  typedef struct packed {
    logic rd_zero;
    logic div_done;
  } dp_sts_t;

  function automatic logic [AW-1:0] cell_addr(input logic [2:0] row, input logic [2:0] col,
                                               input logic [2:0] cols);
    logic [5:0] p;
    p = {3'b000, row} * {3'b000, cols} + {3'b000, col};
    return AW'(p);
  endfunction

  function automatic logic [XAW-1:0] x_index(input logic [2:0] slot, input logic [2:0] idx);
    logic [7:0] p;
    p = {5'b00000, slot} * 8'(MAX_UNKNOWNS) + {5'b00000, idx};
    return XAW'(p);
  endfunction

endpackage

// ===== rtl/core/ges_div.sv =====
// Bit-serial signed divider giving saturated Q16.16 quotients.
module ges_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quot,
  output logic               sat
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] d_r, d_nxt;
  logic        neg_r, neg_nxt;
  logic signed [31:0] quot_r, quot_nxt;
  logic        sat_r, sat_nxt;

  logic [32:0] trial;
  logic        qbit;
  logic [63:0] q_fin;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    quot_nxt = quot_r;
    sat_nxt  = sat_r;
    trial    = {rem_r, quo_r[63]};
    qbit     = (trial >= {1'b0, d_r});
    q_fin    = {quo_r[62:0], qbit};
    if (start) begin
      if (den == 32'sd0) begin
        // A zero divisor saturates by the sign of the numerator.
        done_nxt = 1'b1;
        sat_nxt  = 1'b1;
        quot_nxt = (num > 64'sd0) ? ges_pkg::SAT_MAX :
                   ((num < 64'sd0) ? ges_pkg::SAT_MIN : 32'sd0);
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = '0;
        rem_nxt  = '0;
        quo_nxt  = num[63] ? 64'(-num) : 64'(num);
        d_nxt    = den[31] ? 32'(-den) : 32'(den);
        neg_nxt  = num[63] ^ den[31];
      end
    end else if (busy_r) begin
      rem_nxt = qbit ? 32'(trial - {1'b0, d_r}) : trial[31:0];
      quo_nxt = q_fin;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (neg_r) begin
          sat_nxt  = (q_fin > 64'h0000_0000_8000_0000);
          quot_nxt = sat_nxt ? ges_pkg::SAT_MIN : 32'(-q_fin[31:0]);
        end else begin
          sat_nxt  = (q_fin > 64'h0000_0000_7FFF_FFFF);
          quot_nxt = sat_nxt ? ges_pkg::SAT_MAX : q_fin[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    d_r    <= d_nxt;
    neg_r  <= neg_nxt;
    quot_r <= quot_nxt;
    sat_r  <= sat_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign sat  = sat_r;

endmodule

// ===== rtl/core/ges_dp.sv =====
// Datapath: matrix memory, multiplier, accumulator, divider and result store.
module ges_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ges_pkg::in_item_t   in_item,
  input  ges_pkg::dp_cmd_t    cmd,
  output ges_pkg::dp_sts_t    sts,
  output logic                out_valid,
  output ges_pkg::out_item_t  out_item
);

  logic signed [31:0] mem [ges_pkg::DEPTH];
  logic signed [31:0] xs_r [ges_pkg::XS_DEPTH];
  logic signed [31:0] rd_r, a_r, piv_r, f_r, q_r;
  logic signed [63:0] prod_r;
  logic signed [ges_pkg::ACC_W-1:0] acc_r;
  logic               sat_r, sat_nxt;
  logic               out_valid_r;
  ges_pkg::out_item_t out_r;
  ges_pkg::out_item_t emit_item;

  logic signed [31:0] wdata, xs_rd, mul_b, q_sat, diff_sat, xdata;
  logic signed [63:0] prod_adj, q_full, div_num;
  logic signed [32:0] diff;
  logic               q_ov, diff_ov;
  logic [32:0]        rd_mag;
  logic               div_done, div_sat;
  logic signed [31:0] div_quot;

  assign xs_rd = xs_r[cmd.x_addr];
  assign mul_b = cmd.mul_x ? xs_rd : f_r;

  // Products are truncated toward zero before saturation.
  assign prod_adj = prod_r[63] ? prod_r + 64'sd65535 : prod_r;
  assign q_full   = prod_adj >>> 16;
  assign q_ov     = (q_full > 64'sd2147483647) || (q_full < -64'sd2147483648);
  assign q_sat    = q_ov ? (q_full[63] ? ges_pkg::SAT_MIN : ges_pkg::SAT_MAX) : q_full[31:0];

  assign diff     = {rd_r[31], rd_r} - {q_r[31], q_r};
  assign diff_ov  = diff[32] != diff[31];
  assign diff_sat = diff_ov ? (diff[32] ? ges_pkg::SAT_MIN : ges_pkg::SAT_MAX) : diff[31:0];

  assign rd_mag       = rd_r[31] ? 33'(-{rd_r[31], rd_r}) : {1'b0, rd_r};
  assign sts.rd_zero  = rd_mag <= {17'b0, cmd.thr};
  assign sts.div_done = div_done;

  assign div_num = cmd.div_acc ? (64'(acc_r) <<< 16) : (64'(rd_r) <<< 16);

  ges_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (piv_r),
    .done  (div_done),
    .quot  (div_quot),
    .sat   (div_sat)
  );

  always_comb begin
    case (cmd.wsel)
      ges_pkg::W_IN:   wdata = in_item.matrix_value;
      ges_pkg::W_RD:   wdata = rd_r;
      ges_pkg::W_A:    wdata = a_r;
      ges_pkg::W_DIFF: wdata = diff_sat;
      default:         wdata = 32'sd0;
    endcase
    case (cmd.xsel)
      ges_pkg::X_ONE:  xdata = ges_pkg::Q_ONE;
      ges_pkg::X_QUOT: xdata = div_quot;
      default:         xdata = 32'sd0;
    endcase
  end

  always_comb begin
    emit_item              = cmd.item;
    emit_item.result_value = (cmd.item.result_kind == ges_pkg::KIND_STATUS) ? 32'sd0 : xs_rd;
    emit_item.saturated    = sat_r;
  end

  always_comb begin
    sat_nxt = sat_r;
    if (cmd.sat_clr) begin
      sat_nxt = 1'b0;
    end else begin
      if (cmd.q_en && q_ov) sat_nxt = 1'b1;
      if (cmd.mem_we && cmd.wsel == ges_pkg::W_DIFF && diff_ov) sat_nxt = 1'b1;
      if ((cmd.f_ld || (cmd.x_we && cmd.xsel == ges_pkg::X_QUOT)) && div_sat) sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[cmd.mem_addr] <= wdata;
    if (cmd.mem_re) rd_r <= mem[cmd.mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.x_we) xs_r[cmd.x_addr] <= xdata;
    if (cmd.a_ld) a_r <= rd_r;
    if (cmd.piv_ld) piv_r <= rd_r;
    if (cmd.f_ld) f_r <= div_quot;
    if (cmd.mul_en) prod_r <= rd_r * mul_b;
    if (cmd.q_en) q_r <= q_sat;
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + ges_pkg::ACC_W'(q_r);
    end else if (cmd.num_ld) begin
      acc_r <= (cmd.num_rd ? ges_pkg::ACC_W'(rd_r) : '0) - acc_r;
    end
    if (cmd.emit) out_r <= emit_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sat_r       <= sat_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/core/ges_ctrl.sv =====
// Controller: configuration registers and the sequencer for load, elimination and output.
module ges_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              last_in,
  output logic              busy,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output ges_pkg::dp_cmd_t  cmd,
  input  ges_pkg::dp_sts_t  sts
);

  typedef enum logic [37:0] {
    S_IDLE   = 38'b1 << 0,  S_INIT   = 38'b1 << 1,  S_ECHK   = 38'b1 << 2,
    S_EPIV   = 38'b1 << 3,  S_SRCH   = 38'b1 << 4,  S_SRCH2  = 38'b1 << 5,
    S_SW1    = 38'b1 << 6,  S_SW2    = 38'b1 << 7,  S_SW3    = 38'b1 << 8,
    S_SW4    = 38'b1 << 9,  S_EREC   = 38'b1 << 10, S_F1     = 38'b1 << 11,
    S_F2     = 38'b1 << 12, S_F3     = 38'b1 << 13, S_C1     = 38'b1 << 14,
    S_C2     = 38'b1 << 15, S_C3     = 38'b1 << 16, S_C4     = 38'b1 << 17,
    S_K1     = 38'b1 << 18, S_K2     = 38'b1 << 19, S_K3     = 38'b1 << 20,
    S_K4     = 38'b1 << 21, S_K5     = 38'b1 << 22, S_RANK   = 38'b1 << 23,
    S_VNEXT  = 38'b1 << 24, S_XINIT  = 38'b1 << 25, S_B1     = 38'b1 << 26,
    S_B2     = 38'b1 << 27, S_B3     = 38'b1 << 28, S_B4     = 38'b1 << 29,
    S_B5     = 38'b1 << 30, S_B6     = 38'b1 << 31, S_B7     = 38'b1 << 32,
    S_B8     = 38'b1 << 33, S_B9     = 38'b1 << 34, S_B10    = 38'b1 << 35,
    S_OSTAT  = 38'b1 << 36, S_OVEC   = 38'b1 << 37
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]  rows_cfg_r, unk_cfg_r;
  logic [1:0]  rhs_cfg_r;
  logic [15:0] thr_r;

  logic [ges_pkg::AW-1:0] pos_r, pos_nxt;
  logic [2:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, c_r, c_nxt, t_r, t_nxt, r_r, r_nxt;
  logic [2:0] rn_r, rn_nxt, u_r, u_nxt, v_r, v_nxt, slot_r, slot_nxt, nfree_r, nfree_nxt;
  logic [1:0] cb_r, cb_nxt, pc_r, pc_nxt;
  logic       ph_r, ph_nxt, uniq_r, uniq_nxt;
  logic       oph_r, oph_nxt;
  logic [2:0] on_r, on_nxt, oe_r, oe_nxt;
  logic [1:0] pcol_r [ges_pkg::MAX_ROWS];
  logic [1:0] pcol_nxt [ges_pkg::MAX_ROWS];
  logic [ges_pkg::MAX_ROWS-1:0]     pval_r, pval_nxt;
  logic [ges_pkg::MAX_UNKNOWNS-1:0] basic_r, basic_nxt;
  logic [1:0] free_of_r [ges_pkg::MAX_UNKNOWNS];
  logic [1:0] free_of_nxt [ges_pkg::MAX_UNKNOWNS];

  logic [2:0] act_rows, act_unk, act_cols, act_rhs3, row_b;
  logic [1:0] act_rhs;
  logic [2:0] rank;
  logic [2:0] oslot;

  assign act_rows = (rows_cfg_r == 3'd0) ? 3'd1 :
                    ((rows_cfg_r > 3'(ges_pkg::MAX_ROWS)) ? 3'(ges_pkg::MAX_ROWS) : rows_cfg_r);
  assign act_unk  = (unk_cfg_r == 3'd0) ? 3'd1 :
                    ((unk_cfg_r > 3'(ges_pkg::MAX_UNKNOWNS)) ? 3'(ges_pkg::MAX_UNKNOWNS)
                                                            : unk_cfg_r);
  assign act_rhs  = (rhs_cfg_r == 2'd0) ? 2'd1 :
                    ((rhs_cfg_r > 2'(ges_pkg::MAX_RHS)) ? 2'(ges_pkg::MAX_RHS) : rhs_cfg_r);
  assign act_rhs3 = {1'b0, act_rhs};
  assign act_cols = act_unk + act_rhs3;
  assign row_b    = rn_r - 3'd1;
  assign oslot    = oph_r ? nfree_r + on_r : on_r;
  assign busy     = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= 3'd4;
      unk_cfg_r  <= 3'd4;
      rhs_cfg_r  <= 2'd1;
      thr_r      <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ges_pkg::CFG_ROWS:      rows_cfg_r <= cfg_data[2:0];
        ges_pkg::CFG_UNKNOWNS:  unk_cfg_r  <= cfg_data[2:0];
        ges_pkg::CFG_RHS:       rhs_cfg_r  <= cfg_data[1:0];
        ges_pkg::CFG_THRESHOLD: thr_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; c_nxt = c_r; t_nxt = t_r; r_nxt = r_r;
    rn_nxt = rn_r; u_nxt = u_r; v_nxt = v_r; slot_nxt = slot_r; nfree_nxt = nfree_r;
    cb_nxt = cb_r; pc_nxt = pc_r; ph_nxt = ph_r; uniq_nxt = uniq_r;
    oph_nxt = oph_r; on_nxt = on_r; oe_nxt = oe_r;
    pcol_nxt = pcol_r; pval_nxt = pval_r; basic_nxt = basic_r; free_of_nxt = free_of_r;
    rank = 3'd0;
    cmd = '0;
    cmd.thr = thr_r;
    cmd.item.solve_status = uniq_r ? ges_pkg::STAT_UNIQUE : ges_pkg::STAT_INFINITE;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (32'(pos_r) < ges_pkg::DEPTH) begin
            cmd.mem_we   = 1'b1;
            cmd.wsel     = ges_pkg::W_IN;
            cmd.mem_addr = pos_r;
            pos_nxt      = pos_r + 1'b1;
          end
          if (last_in) begin
            pos_nxt   = '0;
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        pval_nxt    = '0;
        basic_nxt   = '0;
        cmd.sat_clr = 1'b1;
        i_nxt = 3'd0;
        j_nxt = 3'd0;
        state_nxt = S_ECHK;
      end
      S_ECHK: begin
        if (i_r < act_rows && j_r < act_unk) begin
          cmd.mem_re   = 1'b1;
          cmd.mem_addr = ges_pkg::cell_addr(i_r, j_r, act_cols);
          state_nxt    = S_EPIV;
        end else begin
          r_nxt     = 3'd0;
          state_nxt = S_K1;
        end
      end
      S_EPIV: begin
        if (!sts.rd_zero) begin
          cmd.piv_ld = 1'b1;
          state_nxt  = S_EREC;
        end else begin
          t_nxt     = i_r + 3'd1;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (t_r >= act_rows) begin
          j_nxt     = j_r + 3'd1;
          state_nxt = S_ECHK;
        end else begin
          cmd.mem_re   = 1'b1;
          cmd.mem_addr = ges_pkg::cell_addr(t_r, j_r, act_cols);
          state_nxt    = S_SRCH2;
        end
      end
      S_SRCH2: begin
        if (!sts.rd_zero) begin
          cmd.piv_ld = 1'b1;
          c_nxt      = 3'd0;
          state_nxt  = S_SW1;
        end else begin
          t_nxt     = t_r + 3'd1;
          state_nxt = S_SRCH;
        end
      end
      S_SW1: begin
        if (c_r >= act_cols) begin
          state_nxt = S_EREC;
        end else begin
          cmd.mem_re   = 1'b1;
          cmd.mem_addr = ges_pkg::cell_addr(i_r, c_r, act_cols);
          state_nxt    = S_SW2;
        end
      end
      S_SW2: begin
        cmd.a_ld     = 1'b1;
        cmd.mem_re   = 1'b1;
        cmd.mem_addr = ges_pkg::cell_addr(t_r, c_r, act_cols);
        state_nxt    = S_SW3;
      end
      S_SW3: begin
        cmd.mem_we   = 1'b1;
        cmd.wsel     = ges_pkg::W_RD;
        cmd.mem_addr = ges_pkg::cell_addr(i_r, c_r, act_cols);
        state_nxt    = S_SW4;
      end
      S_SW4: begin
        cmd.mem_we   = 1'b1;
        cmd.wsel     = ges_pkg::W_A;
        cmd.mem_addr = ges_pkg::cell_addr(t_r, c_r, act_cols);
        c_nxt        = c_r + 3'd1;
        state_nxt    = S_SW1;
      end
      S_EREC: begin
        pval_nxt[i_r[1:0]] = 1'b1;
        pcol_nxt[i_r[1:0]] = j_r[1:0];
        if (i_r == act_rows - 3'd1) begin
          r_nxt     = 3'd0;
          state_nxt = S_K1;
        end else begin
          k_nxt     = i_r + 3'd1;
          state_nxt = S_F1;
        end
      end
      S_F1: begin
        if (k_r >= act_rows) begin
          if (j_r == act_unk - 3'd1) begin
            r_nxt     = 3'd0;
            state_nxt = S_K1;
          end else begin
            i_nxt     = i_r + 3'd1;
            j_nxt     = j_r + 3'd1;
            state_nxt = S_ECHK;
          end
        end else begin
          cmd.mem_re   = 1'b1;
          cmd.mem_addr = ges_pkg::cell_addr(k_r, j_r, act_cols);
          state_nxt    = S_F2;
        end
      end
      S_F2: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_F3;
      end
      S_F3: begin
        if (sts.div_done) begin
          cmd.f_ld     = 1'b1;
          cmd.mem_we   = 1'b1;
          cmd.wsel     = ges_pkg::W_ZERO;
          cmd.mem_addr = ges_pkg::cell_addr(k_r, j_r, act_cols);
          c_nxt        = j_r + 3'd1;
          state_nxt    = S_C1;
        end
      end
      S_C1: begin
        if (c_r >= act_cols) begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_F1;
        end else begin
          cmd.mem_re   = 1'b1;
          cmd.mem_addr = ges_pkg::cell_addr(i_r, c_r, act_cols);
          state_nxt    = S_C2;
        end
      end
      S_C2: begin
        // The product takes the pivot-row entry while the target entry is fetched.
        cmd.mul_en   = 1'b1;
        cmd.mem_re   = 1'b1;
        cmd.mem_addr = ges_pkg::cell_addr(k_r, c_r, act_cols);
        state_nxt    = S_C3;
      end
      S_C3: begin
        cmd.q_en  = 1'b1;
        state_nxt = S_C4;
      end
      S_C4: begin
        cmd.mem_we   = 1'b1;
        cmd.wsel     = ges_pkg::W_DIFF;
        cmd.mem_addr = ges_pkg::cell_addr(k_r, c_r, act_cols);
        c_nxt        = c_r + 3'd1;
        state_nxt    = S_C1;
      end
      S_K1: begin
        if (r_r >= act_rows) begin
          state_nxt = S_RANK;
        end else begin
          c_nxt     = 3'd0;
          state_nxt = S_K2;
        end
      end
      S_K2: begin
        if (c_r >= act_unk) begin
          cb_nxt    = 2'd0;
          state_nxt = S_K4;
        end else begin
          cmd.mem_re   = 1'b1;
          cmd.mem_addr = ges_pkg::cell_addr(r_r, c_r, act_cols);
          state_nxt    = S_K3;
        end
      end
      S_K3: begin
        if (!sts.rd_zero) begin
          r_nxt     = r_r + 3'd1;
          state_nxt = S_K1;
        end else begin
          c_nxt     = c_r + 3'd1;
          state_nxt = S_K2;
        end
      end
      S_K4: begin
        if (cb_r >= act_rhs) begin
          r_nxt     = r_r + 3'd1;
          state_nxt = S_K1;
        end else begin
          cmd.mem_re   = 1'b1;
          cmd.mem_addr = ges_pkg::cell_addr(r_r, act_unk + {1'b0, cb_r}, act_cols);
          state_nxt    = S_K5;
        end
      end
      S_K5: begin
        if (!sts.rd_zero) begin
          // A zero coefficient row with a nonzero right-hand side: inconsistent.
          cmd.emit              = 1'b1;
          cmd.item.result_kind  = ges_pkg::KIND_STATUS;
          cmd.item.solve_status = ges_pkg::STAT_NONE;
          cmd.item.last_result  = 1'b1;
          state_nxt             = S_IDLE;
        end else begin
          cb_nxt    = cb_r + 2'd1;
          state_nxt = S_K4;
        end
      end
      S_RANK: begin
        basic_nxt = '0;
        for (int n = 0; n < ges_pkg::MAX_ROWS; n++) begin
          if (pval_r[n]) begin
            basic_nxt[pcol_r[n]] = 1'b1;
            rank = rank + 3'd1;
          end
        end
        uniq_nxt  = (rank == act_unk);
        ph_nxt    = (rank == act_unk);
        u_nxt     = 3'd0;
        cb_nxt    = 2'd0;
        nfree_nxt = 3'd0;
        state_nxt = S_VNEXT;
      end
      S_VNEXT: begin
        if (!ph_r) begin
          if (u_r >= act_unk) begin
            ph_nxt = 1'b1;
          end else if (basic_r[u_r[1:0]]) begin
            u_nxt = u_r + 3'd1;
          end else begin
            free_of_nxt[nfree_r[1:0]] = u_r[1:0];
            slot_nxt  = nfree_r;
            v_nxt     = 3'd0;
            state_nxt = S_XINIT;
          end
        end else begin
          if (cb_r >= act_rhs) begin
            state_nxt = S_OSTAT;
          end else begin
            slot_nxt  = nfree_r + {1'b0, cb_r};
            v_nxt     = 3'd0;
            state_nxt = S_XINIT;
          end
        end
      end
      S_XINIT: begin
        cmd.x_we   = 1'b1;
        cmd.x_addr = ges_pkg::x_index(slot_r, v_r);
        cmd.xsel   = (!ph_r && v_r == u_r) ? ges_pkg::X_ONE : ges_pkg::X_ZERO;
        v_nxt      = v_r + 3'd1;
        if (v_r == 3'(ges_pkg::MAX_UNKNOWNS - 1)) begin
          rn_nxt    = act_rows;
          state_nxt = S_B1;
        end
      end
      S_B1: begin
        if (rn_r == 3'd0) begin
          if (!ph_r) begin
            nfree_nxt = nfree_r + 3'd1;
            u_nxt     = u_r + 3'd1;
          end else begin
            cb_nxt = cb_r + 2'd1;
          end
          state_nxt = S_VNEXT;
        end else if (!pval_r[row_b[1:0]]) begin
          rn_nxt = rn_r - 3'd1;
        end else begin
          pc_nxt      = pcol_r[row_b[1:0]];
          k_nxt       = {1'b0, pcol_r[row_b[1:0]]} + 3'd1;
          cmd.acc_clr = 1'b1;
          state_nxt   = S_B2;
        end
      end
      S_B2: begin
        if (k_r >= act_unk) begin
          state_nxt = S_B6;
        end else begin
          cmd.mem_re   = 1'b1;
          cmd.mem_addr = ges_pkg::cell_addr(row_b, k_r, act_cols);
          state_nxt    = S_B3;
        end
      end
      S_B3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_x  = 1'b1;
        cmd.x_addr = ges_pkg::x_index(slot_r, k_r);
        state_nxt  = S_B4;
      end
      S_B4: begin
        cmd.q_en  = 1'b1;
        state_nxt = S_B5;
      end
      S_B5: begin
        cmd.acc_add = 1'b1;
        k_nxt       = k_r + 3'd1;
        state_nxt   = S_B2;
      end
      S_B6: begin
        if (ph_r) begin
          cmd.mem_re   = 1'b1;
          cmd.mem_addr = ges_pkg::cell_addr(row_b, act_unk + {1'b0, cb_r}, act_cols);
        end
        state_nxt = S_B7;
      end
      S_B7: begin
        // Basis vectors have a zero right-hand side.
        cmd.num_ld   = 1'b1;
        cmd.num_rd   = ph_r;
        cmd.mem_re   = 1'b1;
        cmd.mem_addr = ges_pkg::cell_addr(row_b, {1'b0, pc_r}, act_cols);
        state_nxt    = S_B8;
      end
      S_B8: begin
        cmd.piv_ld = 1'b1;
        state_nxt  = S_B9;
      end
      S_B9: begin
        cmd.div_start = 1'b1;
        cmd.div_acc   = 1'b1;
        state_nxt     = S_B10;
      end
      S_B10: begin
        if (sts.div_done) begin
          cmd.x_we   = 1'b1;
          cmd.xsel   = ges_pkg::X_QUOT;
          cmd.x_addr = ges_pkg::x_index(slot_r, {1'b0, pc_r});
          rn_nxt     = rn_r - 3'd1;
          state_nxt  = S_B1;
        end
      end
      S_OSTAT: begin
        cmd.emit             = 1'b1;
        cmd.item.result_kind = ges_pkg::KIND_STATUS;
        oph_nxt   = (nfree_r == 3'd0);
        on_nxt    = 3'd0;
        oe_nxt    = 3'd0;
        state_nxt = S_OVEC;
      end
      S_OVEC: begin
        cmd.emit               = 1'b1;
        cmd.x_addr             = ges_pkg::x_index(oslot, oe_r);
        cmd.item.result_kind   = oph_r ? ges_pkg::KIND_SOLUTION : ges_pkg::KIND_BASIS;
        cmd.item.vector_number = on_r[1:0];
        cmd.item.free_unknown  = oph_r ? 2'd0 : free_of_r[on_r[1:0]];
        cmd.item.unknown_index = oe_r[1:0];
        cmd.item.last_result   = oph_r && on_r == act_rhs3 - 3'd1 && oe_r == act_unk - 3'd1;
        if (oe_r == act_unk - 3'd1) begin
          oe_nxt = 3'd0;
          if (!oph_r && on_r == nfree_r - 3'd1) begin
            oph_nxt = 1'b1;
            on_nxt  = 3'd0;
          end else if (oph_r && on_r == act_rhs3 - 3'd1) begin
            state_nxt = S_IDLE;
          end else begin
            on_nxt = on_r + 3'd1;
          end
        end else begin
          oe_nxt = oe_r + 3'd1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      pval_r  <= '0;
      basic_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      pval_r  <= pval_nxt;
      basic_r <= basic_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; c_r <= c_nxt; t_r <= t_nxt; r_r <= r_nxt;
    rn_r <= rn_nxt; u_r <= u_nxt; v_r <= v_nxt; slot_r <= slot_nxt; nfree_r <= nfree_nxt;
    cb_r <= cb_nxt; pc_r <= pc_nxt; ph_r <= ph_nxt; uniq_r <= uniq_nxt;
    oph_r <= oph_nxt; on_r <= on_nxt; oe_r <= oe_nxt;
    pcol_r <= pcol_nxt;
    free_of_r <= free_of_nxt;
  end

endmodule

// ===== rtl/core/gaussian_elimination_solver.sv =====
// Top level of the Gaussian elimination solver.
//
// Matrix elements enter on in_data, one per transaction, accepted when start is
// high and busy is low; each row holds the coefficient columns then the
// right-hand side columns, signed Q16.16. Loading accepts one element per cycle.
// The element marked last_element starts the solve and busy rises for its
// whole length. Elimination visits each entry below a pivot once, with one
// division per row factor on a 64-step serial divider and a multiply and
// subtract per updated entry; back substitution forms one product per term
// and finishes each pivot row with one division. Results leave on out_data,
// each valid for one cycle under out_valid: a status first, then null-space
// basis vectors, then solutions, the final one marked; an inconsistent system
// gives only the status, itself marked as final. The receiver cannot stall
// the output. Configuration writes on the cfg_ channel are always ready and
// must only be made while busy is low. Reset restores the register defaults
// and the load position; stored matrix entries are undefined until loaded.
module gaussian_elimination_solver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ges_pkg::in_item_t   in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                out_valid,
  output ges_pkg::out_item_t  out_data
);

  ges_pkg::dp_cmd_t cmd;
  ges_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  ges_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_in   (in_data.last_element),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  ges_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule
